[design/efla_pkg.sv]
// Package for the explicit free-list allocator: payload structs, codes,
// sequencer states and memory request bundle. No dependencies.
package efla_pkg;

  localparam int HeapGranules = 4096;
  localparam int PW = 13;   // granule pointer, holds the null value too
  localparam int AW = 12;   // memory index
  localparam int SW = 13;   // block size in granules
  localparam int TW = SW + 2;
  localparam int YW = 14;   // shared adder width

  localparam logic [PW-1:0] NIL = PW'(HeapGranules);
  localparam logic [12:0] LIMIT_RESET = 13'(HeapGranules);

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic        func;
    logic [16:0] req_bytes;
    logic [16:0] payload_addr;
  } req_t;

  typedef struct packed {
    logic [16:0] result_addr;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_OUT,
    A_START, A_CHK, A_CMP, A_SPLIT, A_SPL2, A_SPL3, A_GROW,
    F_START, F_CHK, F_L0, F_L1, F_L2, F_L3, F_R0, F_R1, F_R2, F_R3, F_PUSH,
    T0, T1, R0, R1, P0, P1
  } state_t;

  typedef struct packed {
    logic          tag_we;
    logic [AW-1:0] tag_waddr;
    logic [TW-1:0] tag_wdata;
    logic [AW-1:0] tag_raddr;
    logic          nxt_we;
    logic [AW-1:0] nxt_waddr;
    logic [PW-1:0] nxt_wdata;
    logic          prv_we;
    logic [AW-1:0] prv_waddr;
    logic [PW-1:0] prv_wdata;
    logic [AW-1:0] lnk_raddr;
  } mem_req_t;

endpackage

[design/efla_alu.sv]
// Shared add/subtract unit of the allocator sequencer.
// Depends on efla_pkg.
module efla_alu (
  input  logic [efla_pkg::YW-1:0] a,
  input  logic [efla_pkg::YW-1:0] b,
  input  efla_pkg::alu_op_t       op,
  output logic [efla_pkg::YW-1:0] y
);
  import efla_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a + b;
    endcase
  end

endmodule

[design/efla_store.sv]
// Boundary-tag and free-list link memories, one write port each and
// registered reads. Depends on efla_pkg.
module efla_store (
  input  logic                    clk,
  input  efla_pkg::mem_req_t      mreq,
  output logic [efla_pkg::TW-1:0] tag_rd,
  output logic [efla_pkg::PW-1:0] nxt_rd,
  output logic [efla_pkg::PW-1:0] prv_rd
);
  import efla_pkg::*;

  logic [TW-1:0] tag_mem [HeapGranules];
  logic [PW-1:0] nxt_mem [HeapGranules];
  logic [PW-1:0] prv_mem [HeapGranules];

  always_ff @(posedge clk) begin
    if (mreq.tag_we) begin
      tag_mem[mreq.tag_waddr] <= mreq.tag_wdata;
    end
    tag_rd <= tag_mem[mreq.tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (mreq.nxt_we) begin
      nxt_mem[mreq.nxt_waddr] <= mreq.nxt_wdata;
    end
    nxt_rd <= nxt_mem[mreq.lnk_raddr];
  end

  always_ff @(posedge clk) begin
    if (mreq.prv_we) begin
      prv_mem[mreq.prv_waddr] <= mreq.prv_wdata;
    end
    prv_rd <= prv_mem[mreq.lnk_raddr];
  end

endmodule

[design/explicit_free_list_allocator_core.sv]
// Explicit free-list allocator, first fit, with boundary-tag coalescing.
// Top level: sequencer; uses efla_pkg, efla_alu and efla_store.
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/stall   | req_t (func, req_bytes, payload_addr)
//   out     | output    | out_valid/stall  | rsp_t (result_addr, status)
//   cfg     | input     | cfg_we           | cfg_wdata -> heap_limit
//
// One request at a time. An allocate walks the free list entry by entry, then
// unlinks and splits a block or grows the heap; a free merges the block with
// both neighbors where it can.
// Every step waits on one port of the tag or link memory and one adder.
// Reset is synchronous; memories are not cleared, the heap starts empty.
// The result is held in a register until the output transfer completes.
module explicit_free_list_allocator_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  efla_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output efla_pkg::rsp_t out_data,
  input  logic           cfg_we,
  input  logic [12:0]    cfg_wdata
);
  import efla_pkg::*;

  state_t state, state_next, ret, ret_next;
  req_t req, req_next;
  rsp_t res, res_next;
  logic [YW-1:0] need, need_next, tend, tend_next;
  logic [PW-1:0] cur, cur_next, x, x_next, b, b_next, aux, aux_next;
  logic [PW-1:0] sx, sx_next;
  logic [SW-1:0] sz, sz_next, rem, rem_next, s, s_next, ss, ss_next;
  logic [SW-1:0] asz, asz_next;
  logic sa, sa_next;
  logic [PW-1:0] free_head, free_head_next, first_block, first_block_next;
  logic [PW-1:0] last_block, last_block_next;
  logic [12:0] heap_top, heap_top_next, heap_limit;

  mem_req_t mreq;
  logic [TW-1:0] tag_rd;
  logic [PW-1:0] nxt_rd, prv_rd;
  logic [YW-1:0] alu_a, alu_b, alu_y, need_in;
  alu_op_t alu_op;
  logic [SW-1:0] tag_sz;
  logic [12:0] lim;
  logic fit, rem_ok, grow_ok, fbad, g_oob, fchk_ok, left_ok, lmerge, r_in, rmerge;

  efla_alu u_alu (.a(alu_a), .b(alu_b), .op(alu_op), .y(alu_y));
  efla_store u_store (.clk(clk), .mreq(mreq), .tag_rd(tag_rd), .nxt_rd(nxt_rd),
                      .prv_rd(prv_rd));

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;

  assign tag_sz  = tag_rd[TW-1:2];
  assign lim     = (heap_limit > NIL) ? NIL : heap_limit;
  assign fit     = ({1'b0, tag_sz} >= need);
  assign rem_ok  = (alu_y >= YW'(2));
  assign grow_ok = (alu_y <= {1'b0, lim});
  assign fbad    = (req.payload_addr == 17'd0) || (req.payload_addr[3:0] != 4'd0)
                   || (req.payload_addr[16:4] == 13'd0);
  assign g_oob   = (alu_y >= {1'b0, heap_top});
  assign fchk_ok = (tag_rd[1:0] == 2'b11) && (tag_sz >= SW'(2))
                   && ({1'b0, tag_sz} <= alu_y);
  assign left_ok = (b != first_block) && (b != '0);
  assign lmerge  = !tag_rd[0] && (tag_sz >= SW'(2)) && (tag_sz <= b);
  assign r_in    = (alu_y < {1'b0, heap_top});
  assign rmerge  = !tag_rd[0] && (tag_sz >= SW'(2)) && ({1'b0, tag_sz} <= alu_y);

  // granules needed: payload rounded up plus one header granule, at least two
  always_comb begin
    need_in = {1'b0, in_data.req_bytes[16:4]} + YW'(1)
              + {{(YW-1){1'b0}}, |in_data.req_bytes[3:0]};
    if (need_in < YW'(2)) begin
      need_in = YW'(2);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) begin
                 state_next = (in_data.func == FN_ALLOC) ? A_START : F_START;
               end
      S_OUT:   if (!out_stall) begin
                 state_next = S_IDLE;
               end
      A_START: state_next = (need > {1'b0, NIL}) ? S_OUT : A_CHK;
      A_CHK:   state_next = cur[PW-1] ? A_GROW : A_CMP;
      A_CMP:   state_next = fit ? R0 : A_CHK;
      A_SPLIT: state_next = T0;
      A_SPL2:  state_next = T0;
      A_SPL3:  state_next = P0;
      A_GROW:  state_next = grow_ok ? T0 : S_OUT;
      F_START: state_next = (fbad || g_oob) ? S_OUT : F_CHK;
      F_CHK:   state_next = fchk_ok ? T0 : S_OUT;
      F_L0:    state_next = left_ok ? F_L1 : F_R0;
      F_L1:    state_next = lmerge ? R0 : F_R0;
      F_L2:    state_next = F_L3;
      F_L3:    state_next = T0;
      F_R0:    state_next = r_in ? F_R1 : F_PUSH;
      F_R1:    state_next = rmerge ? R0 : F_PUSH;
      F_R2:    state_next = F_R3;
      F_R3:    state_next = T0;
      F_PUSH:  state_next = P0;
      T0:      state_next = T1;
      T1:      state_next = ret;
      R0:      state_next = R1;
      R1:      state_next = ret;
      P0:      state_next = P1;
      P1:      state_next = ret;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath, memory requests and register updates
  always_comb begin
    ret_next = ret;
    req_next = req;
    res_next = res;
    need_next = need;
    tend_next = tend;
    cur_next = cur;
    x_next = x;
    b_next = b;
    aux_next = aux;
    sx_next = sx;
    sz_next = sz;
    rem_next = rem;
    s_next = s;
    ss_next = ss;
    asz_next = asz;
    sa_next = sa;
    free_head_next = free_head;
    first_block_next = first_block;
    last_block_next = last_block;
    heap_top_next = heap_top;
    alu_a = '0;
    alu_b = '0;
    alu_op = ALU_ADD;
    mreq = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next = in_data;
          need_next = need_in;
          res_next.result_addr = '0;
          res_next.status = ST_DONE;
        end
      end
      A_START: begin
        cur_next = free_head;
        if (need > {1'b0, NIL}) begin
          res_next.status = ST_OOM;
        end
      end
      A_CHK: begin
        mreq.tag_raddr = cur[AW-1:0];
        mreq.lnk_raddr = cur[AW-1:0];
      end
      A_CMP: begin
        sz_next = tag_sz;
        if (fit) begin
          x_next = cur;
          ret_next = A_SPLIT;
        end else begin
          cur_next = nxt_rd;
        end
      end
      A_SPLIT: begin
        alu_a = {1'b0, sz};
        alu_b = need;
        alu_op = ALU_SUB;
        rem_next = alu_y[SW-1:0];
        sx_next = cur;
        sa_next = 1'b1;
        if (rem_ok) begin
          ss_next = need[SW-1:0];
          ret_next = A_SPL2;
        end else begin
          ss_next = sz;
          ret_next = S_OUT;
          res_next.result_addr = {cur + PW'(1), 4'b0000};
        end
      end
      A_SPL2: begin
        alu_a = {1'b0, cur};
        alu_b = need;
        sx_next = alu_y[PW-1:0];
        x_next = alu_y[PW-1:0];
        ss_next = rem;
        sa_next = 1'b0;
        ret_next = A_SPL3;
        if (last_block == cur) begin
          last_block_next = alu_y[PW-1:0];
        end
      end
      A_SPL3: begin
        res_next.result_addr = {cur + PW'(1), 4'b0000};
        ret_next = S_OUT;
      end
      A_GROW: begin
        alu_a = {1'b0, heap_top};
        alu_b = need;
        if (grow_ok) begin
          if (heap_top == '0) begin
            first_block_next = '0;
          end
          last_block_next = heap_top;
          heap_top_next = alu_y[12:0];
          sx_next = heap_top;
          ss_next = need[SW-1:0];
          sa_next = 1'b1;
          ret_next = S_OUT;
          res_next.result_addr = {heap_top + 13'd1, 4'b0000};
        end else begin
          res_next.status = ST_OOM;
        end
      end
      F_START: begin
        alu_a = {1'b0, req.payload_addr[16:4]};
        alu_b = YW'(1);
        alu_op = ALU_SUB;
        b_next = alu_y[PW-1:0];
        mreq.tag_raddr = alu_y[AW-1:0];
        if (fbad || g_oob) begin
          res_next.status = ST_IGNORED;
        end
      end
      F_CHK: begin
        alu_a = {1'b0, heap_top};
        alu_b = {1'b0, b};
        alu_op = ALU_SUB;
        if (fchk_ok) begin
          s_next = tag_sz;
          sx_next = b;
          ss_next = tag_sz;
          sa_next = 1'b0;
          ret_next = F_L0;
        end else begin
          res_next.status = ST_IGNORED;
        end
      end
      F_L0: begin
        alu_a = {1'b0, b};
        alu_b = YW'(1);
        alu_op = ALU_SUB;
        mreq.tag_raddr = alu_y[AW-1:0];
      end
      F_L1: begin
        alu_a = {1'b0, b};
        alu_b = {1'b0, tag_sz};
        alu_op = ALU_SUB;
        if (lmerge) begin
          x_next = alu_y[PW-1:0];
          aux_next = alu_y[PW-1:0];
          asz_next = tag_sz;
          ret_next = F_L2;
        end
      end
      F_L2: begin
        alu_a = {1'b0, b};
        alu_b = YW'(1);
        alu_op = ALU_SUB;
        mreq.tag_we = 1'b1;
        mreq.tag_waddr = alu_y[AW-1:0];
      end
      F_L3: begin
        // clear the header inside the merged block, then retag the whole
        alu_a = {1'b0, s};
        alu_b = {1'b0, asz};
        mreq.tag_we = 1'b1;
        mreq.tag_waddr = b[AW-1:0];
        if (last_block == b) begin
          last_block_next = aux;
        end
        b_next = aux;
        s_next = alu_y[SW-1:0];
        sx_next = aux;
        ss_next = alu_y[SW-1:0];
        sa_next = 1'b0;
        ret_next = F_R0;
      end
      F_R0: begin
        alu_a = {1'b0, b};
        alu_b = {1'b0, s};
        aux_next = alu_y[PW-1:0];
        mreq.tag_raddr = alu_y[AW-1:0];
      end
      F_R1: begin
        alu_a = {1'b0, heap_top};
        alu_b = {1'b0, aux};
        alu_op = ALU_SUB;
        if (rmerge) begin
          x_next = aux;
          asz_next = tag_sz;
          ret_next = F_R2;
        end
      end
      F_R2: begin
        alu_a = {1'b0, aux};
        alu_b = YW'(1);
        alu_op = ALU_SUB;
        mreq.tag_we = 1'b1;
        mreq.tag_waddr = alu_y[AW-1:0];
      end
      F_R3: begin
        alu_a = {1'b0, s};
        alu_b = {1'b0, asz};
        mreq.tag_we = 1'b1;
        mreq.tag_waddr = aux[AW-1:0];
        if (last_block == aux) begin
          last_block_next = b;
        end
        s_next = alu_y[SW-1:0];
        sx_next = b;
        ss_next = alu_y[SW-1:0];
        sa_next = 1'b0;
        ret_next = F_PUSH;
      end
      F_PUSH: begin
        x_next = b;
        ret_next = S_OUT;
      end
      T0: begin
        // header tag, then footer at sx + ss - 1
        mreq.tag_we = 1'b1;
        mreq.tag_waddr = sx[AW-1:0];
        mreq.tag_wdata = {ss, 1'b1, sa};
        alu_a = {1'b0, sx};
        alu_b = {1'b0, ss};
        tend_next = alu_y;
      end
      T1: begin
        alu_a = tend;
        alu_b = YW'(1);
        alu_op = ALU_SUB;
        mreq.tag_we = 1'b1;
        mreq.tag_waddr = alu_y[AW-1:0];
        mreq.tag_wdata = {ss, 1'b0, sa};
      end
      R0: begin
        mreq.lnk_raddr = x[AW-1:0];
      end
      R1: begin
        // unlink x: prv_rd and nxt_rd hold its neighbors
        if (prv_rd[PW-1]) begin
          free_head_next = nxt_rd;
        end else begin
          mreq.nxt_we = 1'b1;
          mreq.nxt_waddr = prv_rd[AW-1:0];
          mreq.nxt_wdata = nxt_rd;
        end
        if (!nxt_rd[PW-1]) begin
          mreq.prv_we = 1'b1;
          mreq.prv_waddr = nxt_rd[AW-1:0];
          mreq.prv_wdata = prv_rd;
        end
      end
      P0: begin
        mreq.nxt_we = 1'b1;
        mreq.nxt_waddr = x[AW-1:0];
        mreq.nxt_wdata = free_head;
        mreq.prv_we = 1'b1;
        mreq.prv_waddr = x[AW-1:0];
        mreq.prv_wdata = NIL;
      end
      P1: begin
        if (!free_head[PW-1]) begin
          mreq.prv_we = 1'b1;
          mreq.prv_waddr = free_head[AW-1:0];
          mreq.prv_wdata = x;
        end
        free_head_next = x;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      free_head <= NIL;
      first_block <= NIL;
      last_block <= NIL;
      heap_top <= '0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      free_head <= free_head_next;
      first_block <= first_block_next;
      last_block <= last_block_next;
      heap_top <= heap_top_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      heap_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    req <= req_next;
    res <= res_next;
    need <= need_next;
    tend <= tend_next;
    cur <= cur_next;
    x <= x_next;
    b <= b_next;
    aux <= aux_next;
    sx <= sx_next;
    sz <= sz_next;
    rem <= rem_next;
    s <= s_next;
    ss <= ss_next;
    asz <= asz_next;
    sa <= sa_next;
  end

endmodule

[tb/tb_top.sv]
// Testbench for explicit_free_list_allocator_core: directed table, then random
// allocate/free traffic checked against an in-bench heap predictor.
// Depends on efla_pkg and the core.
`timescale 1ns / 100ps

module tb_top;
  import efla_pkg::*;

  localparam int NG = 4096;
  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic        func;
    logic [16:0] bytes;
    logic [16:0] addr;
    logic        typed;
    logic [16:0] eaddr;
    logic [1:0]  estat;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;

  always #10 clk = ~clk;

  explicit_free_list_allocator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // heap image
  logic [14:0] heap_tag [NG];
  bit          tag_written [NG];
  logic [12:0] lnk_nxt [NG];
  logic [12:0] lnk_prv [NG];
  int unsigned fl_head, blk_first, blk_last, top_g, lim_reg;

  rsp_t   rsp_q[$];
  int     live_addr[$];
  int     freed_addr[$];
  bit     failed = 1'b0;
  bit     idle_on = 1'b1;
  longint cycles = 0;

  row_t dir_rows [19] = '{
    '{FN_ALLOC, 17'd0,     17'd0,     1'b1, 17'd16, ST_DONE},
    '{FN_ALLOC, 17'd65536, 17'd0,     1'b1, 17'd0,  ST_OOM},
    '{FN_FREE,  17'd0,     17'd0,     1'b1, 17'd0,  ST_IGNORED},
    '{FN_FREE,  17'd0,     17'd1,     1'b1, 17'd0,  ST_IGNORED},
    '{FN_FREE,  17'd0,     17'd65536, 1'b1, 17'd0,  ST_IGNORED},
    '{FN_FREE,  17'd0,     17'd16,    1'b1, 17'd0,  ST_DONE},
    '{FN_FREE,  17'd0,     17'd16,    1'b1, 17'd0,  ST_IGNORED},
    '{FN_ALLOC, 17'd15,    17'd0,     1'b1, 17'd16, ST_DONE},
    '{FN_ALLOC, 17'd16,    17'd0,     1'b0, 17'd0,  ST_DONE},
    '{FN_ALLOC, 17'd200,   17'd0,     1'b0, 17'd0,  ST_DONE},
    '{FN_ALLOC, 17'd40,    17'd0,     1'b0, 17'd0,  ST_DONE},
    '{FN_FREE,  17'd0,     17'd48,    1'b0, 17'd0,  ST_DONE},
    '{FN_FREE,  17'd0,     17'd16,    1'b0, 17'd0,  ST_DONE},
    '{FN_FREE,  17'd0,     17'd80,    1'b0, 17'd0,  ST_DONE},
    '{FN_ALLOC, 17'd0,     17'd0,     1'b0, 17'd0,  ST_DONE},
    '{FN_FREE,  17'd0,     17'd32,    1'b0, 17'd0,  ST_DONE},
    '{FN_ALLOC, 17'd65520, 17'd0,     1'b0, 17'd0,  ST_DONE},
    '{FN_ALLOC, 17'd65535, 17'd0,     1'b1, 17'd0,  ST_OOM},
    '{FN_FREE,  17'd0,     17'd65535, 1'b1, 17'd0,  ST_IGNORED}
  };

  function automatic void put_tag(int unsigned g, int unsigned v);
    if (g < NG) begin
      heap_tag[g] = v[14:0];
      tag_written[g] = 1'b1;
    end
  endfunction

  function automatic int unsigned get_tag(int unsigned g);
    return g < NG ? int'(heap_tag[g]) : 0;
  endfunction

  function automatic void mark_block(int unsigned g, int unsigned sz, int unsigned al);
    put_tag(g, (sz << 2) | 2 | al);
    put_tag(g + sz - 1, (sz << 2) | al);
  endfunction

  function automatic void list_push(int unsigned g);
    if (g >= NG) return;
    lnk_nxt[g] = fl_head[12:0];
    lnk_prv[g] = NIL;
    if (fl_head < NG) lnk_prv[fl_head] = g[12:0];
    fl_head = g;
  endfunction

  function automatic void list_unlink(int unsigned g);
    int unsigned p, n;
    if (g >= NG) return;
    p = lnk_prv[g];
    n = lnk_nxt[g];
    if (p >= NG) fl_head = n;
    else lnk_nxt[p] = n[12:0];
    if (n < NG) lnk_prv[n] = p[12:0];
  endfunction

  function automatic rsp_t alloc_block(int unsigned bytes);
    rsp_t r;
    int unsigned need, cur, steps, sz, lim, g;
    r.result_addr = '0;
    r.status = ST_OOM;
    need = bytes / 16 + 1 + ((bytes % 16) != 0);
    if (need < 2) need = 2;
    if (need > NG) return r;
    cur = fl_head;
    steps = 0;
    while (cur < NG && steps < NG) begin
      sz = heap_tag[cur] >> 2;
      if (sz >= need) begin
        list_unlink(cur);
        if (sz - need >= 2) begin
          mark_block(cur, need, 1);
          mark_block(cur + need, sz - need, 0);
          list_push(cur + need);
          if (blk_last == cur) blk_last = cur + need;
        end else begin
          mark_block(cur, sz, 1);
        end
        r.result_addr = 17'(16 * (cur + 1));
        r.status = ST_DONE;
        return r;
      end
      cur = lnk_nxt[cur];
      steps++;
    end
    lim = lim_reg < NG ? lim_reg : NG;
    if (top_g + need <= lim) begin
      g = top_g;
      if (top_g == 0) blk_first = 0;
      blk_last = g;
      top_g += need;
      mark_block(g, need, 1);
      r.result_addr = 17'(16 * (g + 1));
      r.status = ST_DONE;
    end
    return r;
  endfunction

  function automatic rsp_t release_block(int unsigned addr);
    rsp_t r;
    int unsigned g, t, s, b, ft, sl, left, rr, rt, rs;
    r.result_addr = '0;
    r.status = ST_IGNORED;
    if (addr == 0 || addr % 16 != 0) return r;
    g = addr / 16 - 1;
    if (g >= top_g) return r;
    t = get_tag(g);
    s = t >> 2;
    if ((t & 3) != 3 || s < 2 || s > top_g - g) return r;
    r.status = ST_DONE;
    b = g;
    mark_block(b, s, 0);
    if (b != blk_first && b > 0) begin
      ft = get_tag(b - 1);
      sl = ft >> 2;
      if (!ft[0] && sl >= 2 && sl <= b) begin
        left = b - sl;
        list_unlink(left);
        put_tag(b - 1, 0);
        put_tag(b, 0);
        if (blk_last == b) blk_last = left;
        b = left;
        s += sl;
        mark_block(b, s, 0);
      end
    end
    rr = b + s;
    if (rr < top_g) begin
      rt = get_tag(rr);
      rs = rt >> 2;
      if (!rt[0] && rs >= 2 && rs <= top_g - rr) begin
        list_unlink(rr);
        put_tag(rr - 1, 0);
        put_tag(rr, 0);
        if (blk_last == rr) blk_last = b;
        s += rs;
        mark_block(b, s, 0);
      end
    end
    list_push(b);
    return r;
  endfunction

  function automatic rsp_t heap_step(req_t q);
    rsp_t r;
    int idx;
    if (q.func == FN_ALLOC) begin
      r = alloc_block(q.req_bytes);
      if (r.status == ST_DONE) live_addr.push_back(int'(r.result_addr));
    end else begin
      r = release_block(q.payload_addr);
      if (r.status == ST_DONE) begin
        for (idx = 0; idx < live_addr.size(); idx++)
          if (live_addr[idx] == int'(q.payload_addr)) break;
        if (idx < live_addr.size()) live_addr.delete(idx);
        freed_addr.push_back(int'(q.payload_addr));
        if (freed_addr.size() > 64) void'(freed_addr.pop_front());
      end
    end
    return r;
  endfunction

  // never aim a free at a granule below the heap top whose tag was never written
  function automatic req_t pick_request();
    req_t q;
    int unsigned pick, a, g;
    q = '0;
    q.req_bytes = 17'($urandom_range(0, 131071));
    q.payload_addr = 17'($urandom_range(0, 131071));
    pick = $urandom_range(0, 99);
    if (pick < (live_addr.size() > 150 ? 35 : 55)) begin
      q.func = FN_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 70) q.req_bytes = 17'($urandom_range(0, 255));
      else if (pick < 92) q.req_bytes = 17'($urandom_range(0, 2047));
      else q.req_bytes = 17'($urandom_range(0, 65536));
      return q;
    end
    q.func = FN_FREE;
    pick = $urandom_range(0, 99);
    if (pick < 82 && live_addr.size() > 0) begin
      q.payload_addr = 17'(live_addr[$urandom_range(0, live_addr.size() - 1)]);
    end else if (pick < 86) begin
      q.payload_addr = '0;
    end else if (pick < 90 && freed_addr.size() > 0) begin
      q.payload_addr = 17'(freed_addr[$urandom_range(0, freed_addr.size() - 1)]);
    end else begin
      a = $urandom_range(0, 65536);
      g = a / 16 - 1;
      if (a % 16 == 0 && a >= 16 && g < top_g && !tag_written[g]) a = 0;
      q.payload_addr = 17'(a);
    end
    return q;
  endfunction

  task automatic send_req(input req_t q, input bit typed, input rsp_t want);
    rsp_t got;
    if (idle_on && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (in_stall);
    got = heap_step(q);
    rsp_q.push_back(typed ? want : got);
  endtask

  task automatic set_limit(input int unsigned v);
    in_valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 13'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_reg = v;
  endtask

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) send_req(pick_request(), 1'b0, '0);
  endtask

  // output side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected transfer addr %h status %h",
                 $time, out_data.result_addr, out_data.status);
        failed = 1'b1;
      end else begin
        if (out_data.result_addr !== rsp_q[0].result_addr) begin
          $display("%0t: result_addr expected %h actual %h",
                   $time, rsp_q[0].result_addr, out_data.result_addr);
          failed = 1'b1;
        end
        if (out_data.status !== rsp_q[0].status) begin
          $display("%0t: status expected %h actual %h",
                   $time, rsp_q[0].status, out_data.status);
          failed = 1'b1;
        end
        void'(rsp_q.pop_front());
      end
    end
    out_stall <= !(cycles > 20000 && cycles < 45000) && ($urandom_range(0, 99) < 11);
  end

  initial begin
    req_t q;
    rsp_t w;
    fl_head = NG;
    blk_first = NG;
    blk_last = NG;
    top_g = 0;
    lim_reg = NG;
    for (int i = 0; i < NG; i++) begin
      heap_tag[i] = '0;
      tag_written[i] = 1'b0;
      lnk_nxt[i] = '0;
      lnk_prv[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      q.func = dir_rows[i].func;
      q.req_bytes = dir_rows[i].bytes;
      q.payload_addr = dir_rows[i].addr;
      w.result_addr = dir_rows[i].eaddr;
      w.status = dir_rows[i].estat;
      send_req(q, dir_rows[i].typed, w);
    end

    run_random(380);
    set_limit(1);
    run_random(100);
    set_limit(NG);
    idle_on = 1'b0;
    run_random(200);
    idle_on = 1'b1;
    run_random(120);
    set_limit(64);
    run_random(100);
    set_limit($urandom_range(1, NG));
    run_random(250);

    in_valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!failed && rsp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
design/efla_pkg.sv
design/efla_alu.sv
design/efla_store.sv
design/explicit_free_list_allocator_core.sv
tb/tb_top.sv
